// ===== rtl/core/psch_pkg.sv =====
// Shared types and codes for the priority task scheduler.
package psch_pkg;

  // Scheduler action codes as carried in the action field.
  typedef enum logic [2:0] {
    ACT_CREATE = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_DELAY  = 3'd2,
    ACT_TICK   = 3'd3,
    ACT_SWITCH = 3'd4,
    ACT_END    = 3'd5
  } act_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // One result beat before packing.
  typedef struct packed {
    logic [31:0] tick_count;
    logic [4:0]  current_slot;
    logic        any_ready;
    logic [4:0]  ready_slot;
  } result_t;

  localparam int SLOT_FIELD_W = 5;
  localparam int TICKS_FIELD_W = 32;

endpackage

// ===== rtl/core/priority_task_scheduler_top.sv =====
// Each action passes the states SCAN, DRAIN and EMIT; the result register then drives m_tvalid.
// The action is applied in a one-entry-per-cycle walk of the slot table through the memory's read
//   and write ports; a new action is taken only once the previous result has left the EMIT state.
// Reset (rst, sync, active high): idle top slot valid and running, ticks zero,
//   no memory clearing pass; per-entry written flags stand in for it.
// Result register decouples the output; a new beat is taken while a result waits.
module priority_task_scheduler_top #(
  parameter int SLOT_COUNT  = 32,
  parameter int DELAY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // action[2:0], slot[7:3], ticks[39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // ready_slot[4:0], any_ready[5], current_slot[10:6],
                                 // tick_count[42:11], zero pad [47:43]
);

  // slot index width; a word holds valid, delayed and the delay count
  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int WORD_W = DELAY_WIDTH + 2;

  logic              rd_en, wr_en;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [WORD_W-1:0] rd_data, wr_data;
  logic              res_valid, res_ready;
  psch_pkg::result_t res;

  psch_slot_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (IDX_W),
    .DW    (WORD_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  psch_seq #(
    .SLOT_COUNT  (SLOT_COUNT),
    .DELAY_WIDTH (DELAY_WIDTH),
    .IDX_W       (IDX_W),
    .WORD_W      (WORD_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tdata[2:0]),
    .in_slot   (s_tdata[7:3]),
    .in_ticks  (s_tdata[39:8]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // output register: load when empty or being drained this cycle
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {5'b00000, res.tick_count, res.current_slot, res.any_ready, res.ready_slot};
    end
  end

`ifndef NO_ASSERTIONS
  // one action at a time: the input closes for the scan after each beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken during a scan");

  // an empty ready set reports slot zero
  a_none_ready_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[5]) |-> (m_tdata[4:0] == 5'd0))
    else $error("ready_slot nonzero with no ready slot");

  // the block is idle right after reset
  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> (s_tready && !m_tvalid))
    else $error("not idle after reset");
`endif

endmodule

// ===== rtl/core/psch_slot_mem.sv =====
// Slot table memory: registered synchronous read, per-entry written flags for reset.
module psch_slot_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 34
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  localparam logic [AW-1:0] TopAddr = AW'(DEPTH - 1);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [DW-1:0]    rd_word;
  logic             rd_written;
  logic [AW-1:0]    rd_addr_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word   <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // unwritten entries read as reset value: only the idle slot valid
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
    end
  end

  always_comb begin
    if (rd_written) begin
      rd_data = rd_word;
    end else begin
      rd_data = {(rd_addr_q == TopAddr), 1'b0, (DW - 2)'(0)};
    end
  end

endmodule

// ===== rtl/core/psch_seq.sv =====
// Scan sequencer: walks every slot, applies the action, tracks the first ready slot.
module psch_seq #(
  parameter int SLOT_COUNT  = 32,
  parameter int DELAY_WIDTH = 32,
  parameter int IDX_W       = 5,
  parameter int WORD_W      = 34
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_action,
  input  logic [4:0]          in_slot,
  input  logic [31:0]         in_ticks,
  output logic                res_valid,
  input  logic                res_ready,
  output psch_pkg::result_t   res,
  output logic                rd_en,
  output logic [IDX_W-1:0]    rd_addr,
  input  logic [WORD_W-1:0]   rd_data,
  output logic                wr_en,
  output logic [IDX_W-1:0]    wr_addr,
  output logic [WORD_W-1:0]   wr_data
);

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(SLOT_COUNT - 1);

  psch_pkg::state_t state, state_next;
  psch_pkg::act_t   act;
  logic [4:0]             slot_q;
  logic [DELAY_WIDTH-1:0] ticks_q;
  logic [IDX_W-1:0]       rd_idx;
  logic                   proc_valid;
  logic [IDX_W-1:0]       proc_idx;
  logic                   found_any;
  logic [IDX_W-1:0]       found_idx;
  logic [IDX_W-1:0]       running, running_next;
  logic [31:0]            tick_cnt, tick_next;

  logic                   e_valid, e_delayed;
  logic [DELAY_WIDTH-1:0] e_left;
  logic                   slot_hit, cur_hit, e_ready;
  logic [6:0]             found_wide, run_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psch_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    rd_en      = 1'b0;
    res_valid  = 1'b0;
    case (state)
      psch_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = psch_pkg::ST_SCAN;
      end
      psch_pkg::ST_SCAN: begin
        rd_en = 1'b1;
        if (rd_idx == LastIdx) state_next = psch_pkg::ST_DRAIN;
      end
      psch_pkg::ST_DRAIN: begin
        state_next = psch_pkg::ST_EMIT;
      end
      psch_pkg::ST_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) state_next = psch_pkg::ST_IDLE;
      end
      default: state_next = psch_pkg::ST_IDLE;
    endcase
  end

  assign rd_addr = rd_idx;

  // read-modify-write of the entry returned this cycle
  always_comb begin
    e_valid   = rd_data[WORD_W-1];
    e_delayed = rd_data[WORD_W-2];
    e_left    = rd_data[DELAY_WIDTH-1:0];
    slot_hit  = ({2'b00, slot_q} < 7'(SLOT_COUNT)) && ({2'b00, slot_q} == 7'(proc_idx));
    cur_hit   = (proc_idx == running);
    case (act)
      psch_pkg::ACT_CREATE: begin
        if (slot_hit) begin
          e_valid   = 1'b1;
          e_delayed = 1'b0;
          e_left    = '0;
        end
      end
      psch_pkg::ACT_DELETE: begin
        if (slot_hit) e_valid = 1'b0;
      end
      psch_pkg::ACT_DELAY: begin
        if (cur_hit) begin
          e_left    = ticks_q;
          e_delayed = (ticks_q != '0);
        end
      end
      psch_pkg::ACT_TICK: begin
        if (e_valid && e_delayed) begin
          if (e_left != '0) e_left = e_left - DELAY_WIDTH'(1);
          if (e_left == '0) e_delayed = 1'b0;
        end
      end
      psch_pkg::ACT_END: begin
        if (cur_hit) e_valid = 1'b0;
      end
      default: ;
    endcase
    e_ready = e_valid && !e_delayed;
  end

  assign wr_en   = proc_valid;
  assign wr_addr = proc_idx;
  assign wr_data = {e_valid, e_delayed, e_left};

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_valid <= 1'b0;
      running    <= LastIdx;
      tick_cnt   <= '0;
      found_any  <= 1'b0;
    end else begin
      proc_valid <= rd_en;
      if (state == psch_pkg::ST_IDLE && in_valid) begin
        found_any <= 1'b0;
      end else if (proc_valid && e_ready && !found_any) begin
        found_any <= 1'b1;
      end
      if (res_valid && res_ready) begin
        running  <= running_next;
        tick_cnt <= tick_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= rd_idx;
    if (state == psch_pkg::ST_IDLE && in_valid) begin
      act       <= psch_pkg::act_t'(in_action);
      slot_q    <= in_slot;
      ticks_q   <= in_ticks[DELAY_WIDTH-1:0];
      rd_idx    <= '0;
      found_idx <= '0;
    end else begin
      if (state == psch_pkg::ST_SCAN) rd_idx <= rd_idx + IDX_W'(1);
      if (proc_valid && e_ready && !found_any) found_idx <= proc_idx;
    end
  end

  always_comb begin
    running_next = running;
    if (found_any && (act == psch_pkg::ACT_DELAY || act == psch_pkg::ACT_SWITCH ||
                      act == psch_pkg::ACT_END)) begin
      running_next = found_idx;
    end
    tick_next = (act == psch_pkg::ACT_TICK) ? tick_cnt + 32'd1 : tick_cnt;
    found_wide = 7'(found_idx);
    run_wide   = 7'(running_next);
    res.ready_slot   = found_wide[4:0];
    res.any_ready    = found_any;
    res.current_slot = run_wide[4:0];
    res.tick_count   = tick_next;
  end

endmodule
